>>> rtl/page_fragment_reassembler_macros.svh
// Assertion macros used by the page fragment reassembler top level.
`ifndef PAGE_FRAGMENT_REASSEMBLER_MACROS_SVH
`define PAGE_FRAGMENT_REASSEMBLER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a condition at every clock edge outside reset.
`define PFR_ASSERT(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("pfr: invariant violated");

// Check that an antecedent implies a consequent in the same cycle.
`define PFR_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pfr: implication violated");

// Check that an antecedent implies a consequent in the next cycle.
`define PFR_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pfr: next-cycle check violated");

`else

`define PFR_ASSERT(lbl, clk, rst_n, cond)
`define PFR_IMPLY(lbl, clk, rst_n, ante, cons)
`define PFR_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/pfr_pkg.sv
// Package with types, codes and constants of the page fragment reassembler.
`timescale 1ns / 1ps
`default_nettype none

package pfr_pkg;

	// Field widths of the transaction payloads
	localparam int FUNC_W = 2;
	localparam int ID_W   = 16;
	localparam int CNT_W  = 7;
	localparam int POS_W  = 6;
	localparam int PAY_W  = 32;
	localparam int STAT_W = 3;

	// Stream widths: input tdata 61 bits of fields, output tdata 46 bits of fields
	localparam int IN_TDATA_W   = 64;
	localparam int OUT_FIELDS_W = 1 + POS_W + PAY_W + CNT_W;
	localparam int OUT_TDATA_W  = 48;
	localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

	// Defaults of the top-level parameters
	localparam int DEF_MAX_FRAGMENTS = 64;
	localparam int DEF_PAYLOAD_BITS  = 32;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_PAGE_ID     = 1'b0,
		REG_PAGE_LENGTH = 1'b1
	} reg_idx_t;

	// Item functions
	typedef enum logic [FUNC_W-1:0] {
		FN_ADD   = 2'd0,
		FN_DRAIN = 2'd1,
		FN_CLEAR = 2'd2,
		FN_QUERY = 2'd3
	} func_t;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		STAT_OK          = 3'd0,
		STAT_BAD_ID      = 3'd1,
		STAT_BAD_LEN     = 3'd2,
		STAT_POS_RANGE   = 3'd3,
		STAT_DUP         = 3'd4,
		STAT_INCOMPLETE  = 3'd5,
		STAT_QUERY_RANGE = 3'd6
	} status_t;

	// Controller states
	typedef enum logic [0:0] {
		ST_IDLE  = 1'b0,
		ST_DRAIN = 1'b1
	} state_t;

	// Command to the slot store
	typedef struct packed {
		logic             we;
		logic             re;
		logic [POS_W-1:0] addr;
	} mem_cmd_t;

	// One result item
	typedef struct packed {
		status_t          status;
		logic             slot_filled;
		logic [POS_W-1:0] position;
		logic [PAY_W-1:0] payload;
		logic             last;
		logic [CNT_W-1:0] count;
	} result_t;

	// Address width of a store of the given depth
	function automatic int addr_w(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

	// Stored payload width: the payload field never carries more than PAY_W bits
	function automatic int store_w(input int bits);
		return (bits < PAY_W) ? bits : PAY_W;
	endfunction

endpackage

`default_nettype wire

>>> rtl/pfr_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module pfr_ram
	import pfr_pkg::*;
#(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [addr_w(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and read port; read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/pfr_ctrl.sv
// Controller: item checks, slot valid bits, fill count, drain sequencer, output register.
`timescale 1ns / 1ps
`default_nettype none

module pfr_ctrl
	import pfr_pkg::*;
#(
	parameter int MAX_FRAGMENTS = DEF_MAX_FRAGMENTS,
	parameter int PAYLOAD_BITS  = DEF_PAYLOAD_BITS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// item side
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [FUNC_W-1:0]                  in_func,
	input  wire logic [ID_W-1:0]                    in_fid,
	input  wire logic [CNT_W-1:0]                   in_flen,
	input  wire logic [POS_W-1:0]                   in_pos,
	input  wire logic [PAY_W-1:0]                   in_pay,
	// configuration
	input  wire logic [ID_W-1:0]                    page_id,
	input  wire logic [CNT_W-1:0]                   page_length,
	// slot store
	output mem_cmd_t                                mem_cmd,
	output logic      [store_w(PAYLOAD_BITS)-1:0]   mem_wdata,
	input  wire logic [store_w(PAYLOAD_BITS)-1:0]   mem_rdata,
	// result side
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output result_t                                 out_res
);

	localparam int AddrW  = addr_w(MAX_FRAGMENTS);
	localparam int StoreW = store_w(PAYLOAD_BITS);

	state_t                   state_q, state_d;
	logic [MAX_FRAGMENTS-1:0] valid_q;
	logic [CNT_W-1:0]         fill_q;
	logic [POS_W-1:0]         ctr_q;
	logic                     rd_s1;
	logic [POS_W-1:0]         pos_s1;
	logic                     last_s1;
	logic                     out_valid_q;
	result_t                  out_res_q;

	logic [CNT_W-1:0] len;
	logic             pos_ok;
	logic             cur_valid;
	logic             complete;
	result_t          item_res;
	logic             item_has_res;
	logic             add_ok;
	logic             clr_item;
	logic             start_drain;
	logic             out_free;
	logic             accept;
	logic             load_rd;
	logic             issue;
	logic             issue_last;

	// Effective length: length register saturated to the store depth
	assign len = (page_length > CNT_W'(MAX_FRAGMENTS)) ? CNT_W'(MAX_FRAGMENTS) : page_length;
	assign pos_ok    = {1'b0, in_pos} < len;
	assign cur_valid = valid_q[in_pos[AddrW-1:0]];

	// Page is complete when the count matches and every slot below the length is held
	always_comb begin
		logic all_held;
		all_held = 1'b1;
		for (int i = 0; i < MAX_FRAGMENTS; i++) begin
			if ((CNT_W'(i) < len) && !valid_q[i]) begin
				all_held = 1'b0;
			end
		end
		complete = all_held && (fill_q == page_length);
	end

	// Decode the offered item into its result and store action; a starting drain gives no item result
	always_comb begin
		item_res.status      = STAT_OK;
		item_res.slot_filled = 1'b0;
		item_res.position    = '0;
		item_res.payload     = '0;
		item_res.last        = 1'b1;
		item_res.count       = fill_q;
		item_has_res         = 1'b1;
		add_ok               = 1'b0;
		clr_item             = 1'b0;
		start_drain          = 1'b0;
		unique case (func_t'(in_func))
			FN_ADD: begin
				priority if (in_fid != page_id) begin
					item_res.status = STAT_BAD_ID;
				end else if (in_flen != page_length) begin
					item_res.status = STAT_BAD_LEN;
				end else if (!pos_ok) begin
					item_res.status = STAT_POS_RANGE;
				end else if (cur_valid) begin
					item_res.status = STAT_DUP;
				end else begin
					add_ok         = 1'b1;
					item_res.count = fill_q + CNT_W'(1);
				end
			end
			FN_DRAIN: begin
				priority if (!complete) begin
					item_res.status = STAT_INCOMPLETE;
				end else if (len == '0) begin
					clr_item       = 1'b1;
					item_res.count = '0;
				end else begin
					start_drain  = 1'b1;
					item_has_res = 1'b0;
				end
			end
			FN_CLEAR: begin
				clr_item       = 1'b1;
				item_res.count = '0;
			end
			FN_QUERY: begin
				if (!pos_ok) begin
					item_res.status = STAT_QUERY_RANGE;
				end else begin
					item_res.slot_filled = cur_valid;
				end
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && start_drain) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (issue_last) begin
					state_d = ST_IDLE;
				end
			end
		endcase
	end

	// State outputs: handshake, store reads and writes
	always_comb begin
		out_free   = !out_valid_q || out_ready;
		in_ready   = (state_q == ST_IDLE) && !rd_s1 && out_free;
		accept     = in_valid && in_ready;
		load_rd    = rd_s1 && out_free;
		issue      = (state_q == ST_DRAIN) && (!rd_s1 || load_rd);
		issue_last = issue && ({1'b0, ctr_q} == (len - CNT_W'(1)));
		mem_cmd.we   = accept && add_ok;
		mem_cmd.re   = issue;
		mem_cmd.addr = issue ? ctr_q : in_pos;
	end

	assign mem_wdata = in_pay[StoreW-1:0];

	// Controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Slot valid bits and fill count; a drain empties the store at its last read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fill_q  <= '0;
		end else if ((accept && clr_item) || issue_last) begin
			valid_q <= '0;
			fill_q  <= '0;
		end else if (accept && add_ok) begin
			valid_q[in_pos[AddrW-1:0]] <= 1'b1;
			fill_q                     <= fill_q + CNT_W'(1);
		end
	end

	// Drain read index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= '0;
		end else if (accept && start_drain) begin
			ctr_q <= '0;
		end else if (issue) begin
			ctr_q <= ctr_q + POS_W'(1);
		end
	end

	// Read stage: track the read in flight until the output register takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
		end else if (issue) begin
			rd_s1 <= 1'b1;
		end else if (load_rd) begin
			rd_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			pos_s1  <= ctr_q;
			last_s1 <= issue_last;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((accept && item_has_res) || load_rd) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload: item result or drained fragment
	always_ff @(posedge clk) begin
		if (accept && item_has_res) begin
			out_res_q <= item_res;
		end else if (load_rd) begin
			out_res_q.status      <= STAT_OK;
			out_res_q.slot_filled <= 1'b0;
			out_res_q.position    <= pos_s1;
			out_res_q.payload     <= PAY_W'(mem_rdata);
			out_res_q.last        <= last_s1;
			out_res_q.count       <= len - CNT_W'(1) - {1'b0, pos_s1};
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

endmodule

`default_nettype wire

>>> rtl/page_fragment_reassembler.sv
// Top level of the page fragment reassembler: configuration, slot store, controller.
//
// Channel    Direction  Handshake          Contents
// s_*        in         s_tvalid/s_tready  item: func in tuser, fragment fields in tdata
// m_*        out        m_tvalid/m_tready  result: status in tuser, last in tlast
// cfg_*      in         cfg_wen            register write, index and data
//
// Add, clear, query and a failing or empty drain each give one result.
// A complete drain of L fragments gives L results, one per cycle when unstalled,
// read from the single port of the slot store; the next item is taken once the
// last drained result has entered the output register.
// Reset loads page id 0 and length 1, clears valid bits, fill count and control;
// the store needs no clearing pass. m_tready low holds a waiting result, stalling input.
`timescale 1ns / 1ps
`default_nettype none

`include "page_fragment_reassembler_macros.svh"

module page_fragment_reassembler
	import pfr_pkg::*;
#(
	parameter int MAX_FRAGMENTS = DEF_MAX_FRAGMENTS,
	parameter int PAYLOAD_BITS  = DEF_PAYLOAD_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration
	input  wire logic                   cfg_wen,
	input  wire logic [0:0]             cfg_index,
	input  wire logic [ID_W-1:0]        cfg_wdata,
	// item stream
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// frag_page_id, frag_page_length, frag_position, frag_payload, zero pad
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// func
	input  wire logic [FUNC_W-1:0]      s_tuser,
	// result stream
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// slot_filled, out_position, out_payload, filled_count, zero pad
	output logic      [OUT_TDATA_W-1:0] m_tdata,
	// status
	output logic      [STAT_W-1:0]      m_tuser,
	output logic                        m_tlast
);

	localparam int AddrW  = addr_w(MAX_FRAGMENTS);
	localparam int StoreW = store_w(PAYLOAD_BITS);

	logic [ID_W-1:0]   page_id_q;
	logic [CNT_W-1:0]  page_length_q;
	mem_cmd_t          mem_cmd;
	logic [StoreW-1:0] mem_wdata;
	logic [StoreW-1:0] mem_rdata;
	result_t           res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_id_q     <= '0;
			page_length_q <= CNT_W'(1);
		end else if (cfg_wen) begin
			unique case (reg_idx_t'(cfg_index))
				REG_PAGE_ID:     page_id_q     <= cfg_wdata;
				REG_PAGE_LENGTH: page_length_q <= cfg_wdata[CNT_W-1:0];
			endcase
		end
	end

	// Slot store
	pfr_ram #(
		.WIDTH (StoreW),
		.DEPTH (MAX_FRAGMENTS)
	) u_store (
		.clk   (clk),
		.we    (mem_cmd.we),
		.re    (mem_cmd.re),
		.addr  (mem_cmd.addr[AddrW-1:0]),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Controller
	pfr_ctrl #(
		.MAX_FRAGMENTS (MAX_FRAGMENTS),
		.PAYLOAD_BITS  (PAYLOAD_BITS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_func     (s_tuser),
		.in_fid      (s_tdata[15:0]),
		.in_flen     (s_tdata[22:16]),
		.in_pos      (s_tdata[28:23]),
		.in_pay      (s_tdata[60:29]),
		.page_id     (page_id_q),
		.page_length (page_length_q),
		.mem_cmd     (mem_cmd),
		.mem_wdata   (mem_wdata),
		.mem_rdata   (mem_rdata),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_res     (res)
	);

	// Pack the result transaction
	assign m_tdata = {{OUT_PAD_W{1'b0}}, res.count, res.payload, res.position, res.slot_filled};
	assign m_tuser = res.status;
	assign m_tlast = res.last;

	// The single store port never reads and writes in one cycle
	`PFR_ASSERT(a_port_excl, clk, arst_n, !(mem_cmd.we && mem_cmd.re))
	// Stores happen only on an accepted item
	`PFR_IMPLY(a_write_on_accept, clk, arst_n, mem_cmd.we, s_tvalid && s_tready)
	// No item is taken while a drain reads the store
	`PFR_IMPLY(a_no_take_in_drain, clk, arst_n, mem_cmd.re, !s_tready)
	// A drain read is followed by a pending result
	`PFR_NEXT(a_read_gives_result, clk, arst_n, mem_cmd.re, !s_tready)

endmodule

`default_nettype wire
